[rtl/hue_rotate_color_matrix_unit_assert.svh]
// Assertion macros for the hue rotation color matrix unit.
// Included by the top level; depends on nothing else.
`ifndef HUE_ROTATE_COLOR_MATRIX_UNIT_ASSERT_SVH
`define HUE_ROTATE_COLOR_MATRIX_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HRCM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HRCM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hrcm_pkg.sv]
// Shared types, widths and coefficient tables of the hue rotation color matrix unit.
// Used by every RTL file but the assertion header; depends on nothing.
`timescale 1ns / 1ps

package hrcm_pkg;

    // Fixed-point formats.
    localparam int COEF_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 14;
    localparam int ANGLE_W         = 16;
    localparam int CHAN_W          = 8;
    localparam int SUM_SHIFT       = ANGLE_FRAC_BITS + COEF_FRAC_BITS;

    // Rounded constants stay below 2^COEF_FRAC_BITS in magnitude.
    localparam int CONST_W = COEF_FRAC_BITS + 1;
    // A coefficient holds cos and sine terms plus the scaled luma term.
    localparam int COEF_W  = ANGLE_W + CONST_W;
    localparam int PROD_W  = COEF_W + CHAN_W + 1;
    localparam int DOT_W   = PROD_W + 2;
    // Row-sum bits above the integer channel field; any set bit saturates.
    localparam int SAT_HI_W = DOT_W - SUM_SHIFT - CHAN_W;

    localparam int NUM_CH     = 3;
    localparam int NUM_COEF   = NUM_CH * NUM_CH;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);

    // Queue between the accept side and the arithmetic side.
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE = 1'b1;

    localparam logic signed [ANGLE_W-1:0] COS_RESET = ANGLE_W'(1 << ANGLE_FRAC_BITS);
    localparam logic signed [ANGLE_W-1:0] SIN_RESET = '0;

    typedef logic [CHAN_W-1:0]          t_chan;
    typedef logic signed [ANGLE_W-1:0]  t_angle;
    typedef logic signed [CONST_W-1:0]  t_qconst;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [DOT_W-1:0]    t_dot;
    typedef logic [COEF_IDX_W-1:0]      t_coef_idx;

    typedef t_coef   t_coef_set [NUM_COEF];
    typedef t_qconst t_qtab [NUM_COEF];
    typedef int      t_milli_tab [NUM_COEF][NUM_CH];

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pix;

    typedef struct packed {
        logic valid;
        t_pix pix;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic busy;
    } t_front_status;

    // Columns of the constant table: luma, cosine factor, sine factor.
    localparam int COL_LUMA = 0;
    localparam int COL_COS  = 1;
    localparam int COL_SIN  = 2;

    // Matrix constants in thousandths, row-major.
    localparam t_milli_tab MAT_MILLI = '{
        '{213,  787, -213},
        '{715, -715, -715},
        '{ 72,  -72,  928},
        '{213, -213,  143},
        '{715,  285,  140},
        '{ 72,  -72, -283},
        '{213, -213, -787},
        '{715, -715,  715},
        '{ 72,  928,   72}
    };

    // Rounds one column of thousandths to COEF_FRAC_BITS fractional bits,
    // half away from zero.
    function automatic t_qtab make_qtab(int col);
        t_qtab  tab;
        int     m;
        longint mag;
        longint q;
        for (int k = 0; k < NUM_COEF; k++) begin
            m   = MAT_MILLI[k][col];
            mag = (m < 0) ? longint'(-m) : longint'(m);
            q   = ((mag << COEF_FRAC_BITS) + 500) / 1000;
            if (m < 0) begin
                q = -q;
            end
            tab[k] = CONST_W'(q);
        end
        return tab;
    endfunction

    localparam t_qtab Q_LUMA = make_qtab(COL_LUMA);
    localparam t_qtab Q_COS  = make_qtab(COL_COS);
    localparam t_qtab Q_SIN  = make_qtab(COL_SIN);

endpackage

[rtl/hrcm_in_if.sv]
// Input pixel channel: valid/ready handshake with an RGB payload.
// Depends on hrcm_pkg for the channel type.
`timescale 1ns / 1ps

interface hrcm_in_if;
    logic             valid;
    logic             ready;
    hrcm_pkg::t_chan  red_in;
    hrcm_pkg::t_chan  green_in;
    hrcm_pkg::t_chan  blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

[rtl/hrcm_out_if.sv]
// Output pixel channel: valid/ready handshake with the rotated RGB payload.
// Depends on hrcm_pkg for the channel type.
`timescale 1ns / 1ps

interface hrcm_out_if;
    logic             valid;
    logic             ready;
    hrcm_pkg::t_chan  red_out;
    hrcm_pkg::t_chan  green_out;
    hrcm_pkg::t_chan  blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

[rtl/hue_rotate_color_matrix_unit.sv]
// Hue rotation color matrix unit: top level joining intake, queue and arithmetic.
// Depends on hrcm_pkg, hrcm_in_if, hrcm_out_if, hrcm_front, hrcm_queue, hrcm_back
// and the assertion macro header.
//
// Usage:
// - i_pix carries one RGB pixel per request; o_pix returns the rotated pixel.
//   Both use valid/ready; a request moves when valid and ready are high.
// - Software writes cos_angle (index 0) and sin_angle (index 1), signed Q2.14,
//   through i_cfg_we, i_cfg_idx and i_cfg_data while the block is idle.
// - Each write starts a sweep that rebuilds the nine coefficients with one
//   pair of multipliers, one coefficient a cycle; i_pix.ready stays low from
//   the write until the sweep and its final add complete.
// - Throughput is one pixel per cycle unless a sweep runs or the receiver stalls.
//   An accepted pixel passes the queue, product register and output register.
// - Reset loads cos = 1 and sin = 0 and runs the same sweep, which
//   yields the identity matrix; no pixel is accepted during it.
// - When the receiver stalls, the result holds in the output register, the
//   product stage holds behind it, and the four-entry queue keeps taking
//   pixels until it fills; ready then drops.
`timescale 1ns / 1ps
`include "hue_rotate_color_matrix_unit_assert.svh"

module hue_rotate_color_matrix_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hrcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hrcm_pkg::ANGLE_W-1:0]    i_cfg_data,
    hrcm_in_if.sink                         i_pix,
    hrcm_out_if.source                      o_pix
);

    hrcm_pkg::t_q_push        w_q_push;
    hrcm_pkg::t_q_status      w_q_stat;
    hrcm_pkg::t_pix           w_q_head;
    logic                     w_q_pop;
    hrcm_pkg::t_coef_set      w_coef;
    hrcm_pkg::t_front_status  w_front_stat;

    // Intake and coefficient sequencer.
    hrcm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_stat   (w_q_stat),
        .o_q_push   (w_q_push),
        .o_coef     (w_coef),
        .o_status   (w_front_stat)
    );

    // Decoupling queue.
    hrcm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_pop    (w_q_pop),
        .o_stat   (w_q_stat),
        .o_head   (w_q_head)
    );

    // Matrix arithmetic and output register.
    hrcm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (w_coef),
        .i_q_stat (w_q_stat),
        .i_q_head (w_q_head),
        .o_q_pop  (w_q_pop),
        .o_pix    (o_pix)
    );

    // No pixel may enter while coefficients are being rebuilt.
    `HRCM_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, w_front_stat.busy, !i_pix.ready,
                     "pixel accepted during coefficient sweep")
    // A register write always starts a sweep.
    `HRCM_ASSERT_NXT(a_cfg_starts_sweep, i_clk, i_rst_n, i_cfg_we, w_front_stat.busy,
                     "register write did not start a sweep")
    // The queue never takes a pixel when full.
    `HRCM_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_q_stat.full, !w_q_push.valid,
                     "push into full queue")
    // The arithmetic side never reads an empty queue.
    `HRCM_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, w_q_pop, !w_q_stat.empty,
                     "pop from empty queue")

endmodule

[rtl/hrcm_queue.sv]
// Small register FIFO that carries accepted pixels to the arithmetic side.
// Depends on hrcm_pkg.
`timescale 1ns / 1ps

module hrcm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hrcm_pkg::t_q_push     i_push,
    input  logic                  i_pop,
    output hrcm_pkg::t_q_status   o_stat,
    output hrcm_pkg::t_pix        o_head
);

    hrcm_pkg::t_pix                   r_mem [hrcm_pkg::QUEUE_DEPTH];
    logic [hrcm_pkg::Q_PTR_W-1:0]     r_wr, n_wr;
    logic [hrcm_pkg::Q_PTR_W-1:0]     r_rd, n_rd;
    logic [hrcm_pkg::Q_CNT_W-1:0]     r_cnt, n_cnt;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.valid) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.pix;
        end
    end

    assign o_stat.full  = (r_cnt == hrcm_pkg::Q_CNT_W'(hrcm_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

endmodule

[rtl/hrcm_front.sv]
// Accept side: angle registers, coefficient sequencer and pixel intake.
// Depends on hrcm_pkg and hrcm_in_if.
`timescale 1ns / 1ps

module hrcm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hrcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hrcm_pkg::ANGLE_W-1:0]    i_cfg_data,
    hrcm_in_if.sink                         i_pix,
    input  hrcm_pkg::t_q_status             i_q_stat,
    output hrcm_pkg::t_q_push               o_q_push,
    output hrcm_pkg::t_coef_set             o_coef,
    output hrcm_pkg::t_front_status         o_status
);

    hrcm_pkg::t_angle      r_cos, n_cos;
    hrcm_pkg::t_angle      r_sin, n_sin;
    logic                  r_busy, n_busy;
    hrcm_pkg::t_coef_idx   r_k, n_k;
    logic                  r_p_valid, n_p_valid;
    hrcm_pkg::t_coef_idx   r_p_idx, n_p_idx;
    hrcm_pkg::t_coef       r_p_cos, n_p_cos;
    hrcm_pkg::t_coef       r_p_sin, n_p_sin;
    hrcm_pkg::t_coef       r_p_luma, n_p_luma;
    hrcm_pkg::t_coef_set   r_coef;
    hrcm_pkg::t_coef       w_coef_new;
    logic                  w_busy;

    // Sweep over the nine coefficients: the first step forms the cosine and
    // sine products, the second adds the scaled luma constant and stores.
    always_comb begin
        n_cos     = r_cos;
        n_sin     = r_sin;
        n_busy    = r_busy;
        n_k       = r_k;
        n_p_valid = r_busy;
        n_p_idx   = r_k;
        n_p_cos   = hrcm_pkg::t_coef'(r_cos) * hrcm_pkg::t_coef'(hrcm_pkg::Q_COS[r_k]);
        n_p_sin   = hrcm_pkg::t_coef'(r_sin) * hrcm_pkg::t_coef'(hrcm_pkg::Q_SIN[r_k]);
        n_p_luma  = hrcm_pkg::t_coef'(hrcm_pkg::Q_LUMA[r_k]) <<< hrcm_pkg::ANGLE_FRAC_BITS;
        // The index parks at the first coefficient once the sweep ends.
        if (r_busy) begin
            if (r_k == hrcm_pkg::t_coef_idx'(hrcm_pkg::NUM_COEF - 1)) begin
                n_busy = 1'b0;
                n_k    = '0;
            end else begin
                n_k = r_k + 1'b1;
            end
        end
        // A register write restarts the sweep from the first coefficient.
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hrcm_pkg::REG_COS_ANGLE: n_cos = i_cfg_data;
                hrcm_pkg::REG_SIN_ANGLE: n_sin = i_cfg_data;
                default:                 n_cos = r_cos;
            endcase
            n_busy    = 1'b1;
            n_k       = '0;
            n_p_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos     <= hrcm_pkg::COS_RESET;
            r_sin     <= hrcm_pkg::SIN_RESET;
            r_busy    <= 1'b1;
            r_k       <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_cos     <= n_cos;
            r_sin     <= n_sin;
            r_busy    <= n_busy;
            r_k       <= n_k;
            r_p_valid <= n_p_valid;
        end
    end

    // Product registers and coefficient storage carry no reset.
    always_ff @(posedge i_clk) begin
        r_p_idx  <= n_p_idx;
        r_p_cos  <= n_p_cos;
        r_p_sin  <= n_p_sin;
        r_p_luma <= n_p_luma;
        if (r_p_valid) begin
            r_coef[r_p_idx] <= w_coef_new;
        end
    end

    assign w_coef_new = r_p_luma + r_p_cos + r_p_sin;
    assign w_busy     = r_busy || r_p_valid;

    // Pixels enter only with settled coefficients, queue room and no register write.
    assign i_pix.ready        = !w_busy && !i_q_stat.full && !i_cfg_we;
    assign o_q_push.valid     = i_pix.valid && i_pix.ready;
    assign o_q_push.pix.red   = i_pix.red_in;
    assign o_q_push.pix.green = i_pix.green_in;
    assign o_q_push.pix.blue  = i_pix.blue_in;

    assign o_coef          = r_coef;
    assign o_status.busy   = w_busy;

endmodule

[rtl/hrcm_back.sv]
// Arithmetic side: nine products, row sums, clamp and the output register.
// Depends on hrcm_pkg and hrcm_out_if.
`timescale 1ns / 1ps

module hrcm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hrcm_pkg::t_coef_set       i_coef,
    input  hrcm_pkg::t_q_status       i_q_stat,
    input  hrcm_pkg::t_pix            i_q_head,
    output logic                      o_q_pop,
    hrcm_out_if.source                o_pix
);

    logic                  r_v1;
    logic                  r_v2;
    hrcm_pkg::t_prod       r_prod [hrcm_pkg::NUM_COEF];
    hrcm_pkg::t_prod       w_prod [hrcm_pkg::NUM_COEF];
    hrcm_pkg::t_prod       w_chan [hrcm_pkg::NUM_CH];
    hrcm_pkg::t_chan       w_res  [hrcm_pkg::NUM_CH];
    hrcm_pkg::t_pix        r_out;
    logic                  w_out_free;
    logic                  w_s1_free;

    // Floors the row sum to an integer and saturates it to the channel range.
    function automatic hrcm_pkg::t_chan clamp_chan(hrcm_pkg::t_dot sum);
        hrcm_pkg::t_chan res;
        if (sum[hrcm_pkg::DOT_W-1]) begin
            res = '0;
        end else if (sum[hrcm_pkg::DOT_W-1 -: hrcm_pkg::SAT_HI_W] != '0) begin
            res = '1;
        end else begin
            res = sum[hrcm_pkg::SUM_SHIFT +: hrcm_pkg::CHAN_W];
        end
        return res;
    endfunction

    // Stage flow: each stage loads when it is empty or its successor moves.
    assign w_out_free = !r_v2 || o_pix.ready;
    assign w_s1_free  = !r_v1 || w_out_free;
    assign o_q_pop    = !i_q_stat.empty && w_s1_free;

    // Coefficient times channel for every matrix entry.
    always_comb begin
        w_chan[0] = hrcm_pkg::t_prod'({1'b0, i_q_head.red});
        w_chan[1] = hrcm_pkg::t_prod'({1'b0, i_q_head.green});
        w_chan[2] = hrcm_pkg::t_prod'({1'b0, i_q_head.blue});
        for (int row = 0; row < hrcm_pkg::NUM_CH; row++) begin
            for (int col = 0; col < hrcm_pkg::NUM_CH; col++) begin
                w_prod[row * hrcm_pkg::NUM_CH + col] =
                    hrcm_pkg::t_prod'(i_coef[row * hrcm_pkg::NUM_CH + col]) * w_chan[col];
            end
        end
    end

    // Row sums and saturation.
    always_comb begin
        for (int row = 0; row < hrcm_pkg::NUM_CH; row++) begin
            w_res[row] = clamp_chan(
                hrcm_pkg::t_dot'(r_prod[row * hrcm_pkg::NUM_CH])
              + hrcm_pkg::t_dot'(r_prod[row * hrcm_pkg::NUM_CH + 1])
              + hrcm_pkg::t_dot'(r_prod[row * hrcm_pkg::NUM_CH + 2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_v1 <= o_q_pop;
            end
            if (w_out_free) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload registers load with their stage and need no reset.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_prod <= w_prod;
        end
        if (w_out_free && r_v1) begin
            r_out.red   <= w_res[0];
            r_out.green <= w_res[1];
            r_out.blue  <= w_res[2];
        end
    end

    assign o_pix.valid     = r_v2;
    assign o_pix.red_out   = r_out.red;
    assign o_pix.green_out = r_out.green;
    assign o_pix.blue_out  = r_out.blue;

endmodule
